@@ hdl/rmd_pkg.sv @@
package rmd_pkg;

   // Default buffer size in bytes
   localparam int RMD_BUF_BYTES = 512;

   // Fixed field widths
   localparam int STR_LEN_W = 9;
   localparam int PHASE_W   = 4;

   // Parser phases
   localparam logic [PHASE_W-1:0] PH_TYPE      = 4'd0;
   localparam logic [PHASE_W-1:0] PH_SIGN      = 4'd1;
   localparam logic [PHASE_W-1:0] PH_DIGITS    = 4'd2;
   localparam logic [PHASE_W-1:0] PH_NUM_LF    = 4'd3;
   localparam logic [PHASE_W-1:0] PH_TEXT      = 4'd4;
   localparam logic [PHASE_W-1:0] PH_TEXT_LF   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_BULK_DATA = 4'd6;
   localparam logic [PHASE_W-1:0] PH_BULK_CR   = 4'd7;
   localparam logic [PHASE_W-1:0] PH_BULK_LF   = 4'd8;
   localparam logic [PHASE_W-1:0] PH_DRAIN     = 4'd9;

   // Message types
   localparam logic [2:0] TY_SIMPLE = 3'd0;
   localparam logic [2:0] TY_ERROR  = 3'd1;
   localparam logic [2:0] TY_INT    = 3'd2;
   localparam logic [2:0] TY_BULK   = 3'd3;
   localparam logic [2:0] TY_NULL   = 3'd4;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
   localparam logic [2:0] ST_FRAMING   = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_NO_DIGITS = 3'd4;
   localparam logic [2:0] ST_NEGATIVE  = 3'd5;
   localparam logic [2:0] ST_TOO_LONG  = 3'd6;
   localparam logic [2:0] ST_TRUNCATED = 3'd7;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_FINAL   = 1'b1;

   // Protocol characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Signed 32-bit magnitude limits
   localparam logic [35:0] LIMIT_POS = 36'h07FFFFFFF;
   localparam logic [35:0] LIMIT_NEG = 36'h080000000;

   // Parser context, apart from the byte counters
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [2:0]         type_code;
      logic [31:0]        magnitude;
      logic               is_negative;
      logic               digit_seen;
   } rmd_state_type;

   // One result item
   typedef struct packed {
      logic                 result_kind;
      logic [7:0]           payload_byte;
      logic [2:0]           msg_type;
      logic signed [31:0]   int_value;
      logic [STR_LEN_W-1:0] str_length;
      logic [2:0]           status;
   } rmd_result_type;

endpackage

@@ hdl/rmd_req_if.sv @@
interface rmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

@@ hdl/rmd_rsp_if.sv @@
interface rmd_rsp_if
   import rmd_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic                 result_kind;
   logic [7:0]           payload_byte;
   logic [2:0]           msg_type;
   logic signed [31:0]   int_value;
   logic [STR_LEN_W-1:0] str_length;
   logic [2:0]           status;

   modport source (output valid, output result_kind, output payload_byte, output msg_type,
                   output int_value, output str_length, output status, input ready);
   modport sink   (input valid, input result_kind, input payload_byte, input msg_type,
                   input int_value, input str_length, input status, output ready);
endinterface

@@ hdl/resp_message_decoder_core.sv @@
// Channel  Dir  Port    Item
// -------  ---  ------  -----------------------------------------------------
// request  in   req_if  data_byte, buffer_end
// result   out  rsp_if  result_kind, payload_byte, msg_type, int_value,
//                       str_length, status
//
// One byte per cycle unless a held result stalls the input register; a byte is
// accepted into the input register and its result is held in the result register.
// Each byte is parsed in a single pass of the step logic between the two.
// reset (synchronous) returns the parser to waiting for a type byte.
// A held result only stalls the input register when its byte also yields a
// result; bytes with no result keep flowing.
module resp_message_decoder_core
   import rmd_pkg::*;
#(
   parameter int BUF_BYTES = RMD_BUF_BYTES
) (
   input logic       clock,
   input logic       reset,
   rmd_req_if.sink   req_if,
   rmd_rsp_if.source rsp_if
);

   localparam int CNT_W = $clog2(BUF_BYTES);

   // Input register
   logic             in_vld_ff, in_vld_in;
   logic [7:0]       in_data_ff, in_data_in;
   logic             in_end_ff, in_end_in;

   // Parser context
   rmd_state_type    st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;

   // Result register
   logic             out_vld_ff, out_vld_in;
   rmd_result_type   out_res_ff, out_res_in;

   rmd_state_type    step_state;
   logic [CNT_W-1:0] step_count;
   logic [CNT_W-1:0] step_rem;
   logic             step_fire;
   rmd_result_type   step_res;
   logic             out_free;
   logic             in_move;

   rmd_step #(
      .BUF_BYTES (BUF_BYTES),
      .CNT_W     (CNT_W)
   ) u_step (
      .cur_state     (st_ff),
      .cur_count     (cnt_ff),
      .cur_remaining (rem_ff),
      .data_byte     (in_data_ff),
      .buffer_end    (in_end_ff),
      .nxt_state     (step_state),
      .nxt_count     (step_count),
      .nxt_remaining (step_rem),
      .fire          (step_fire),
      .result        (step_res)
   );

   // Flow control
   assign out_free     = !out_vld_ff || rsp_if.ready;
   assign in_move      = in_vld_ff && (!step_fire || out_free);
   assign req_if.ready = !in_vld_ff || in_move;

   // Next values
   always_comb begin
      in_vld_in  = in_vld_ff;
      in_data_in = in_data_ff;
      in_end_in  = in_end_ff;
      if (req_if.ready) begin
         in_vld_in  = req_if.valid;
         in_data_in = req_if.data_byte;
         in_end_in  = req_if.buffer_end;
      end

      st_in  = st_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      if (in_move) begin
         st_in  = step_state;
         cnt_in = step_count;
         rem_in = step_rem;
      end

      out_vld_in = out_vld_ff;
      out_res_in = out_res_ff;
      if (in_move && step_fire) begin
         out_vld_in = 1'b1;
         out_res_in = step_res;
      end else if (rsp_if.ready) begin
         out_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         st_ff      <= '{phase: PH_TYPE, type_code: TY_SIMPLE, magnitude: '0,
                         is_negative: 1'b0, digit_seen: 1'b0};
         cnt_ff     <= '0;
         rem_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         st_ff      <= st_in;
         cnt_ff     <= cnt_in;
         rem_ff     <= rem_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_end_ff  <= in_end_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.result_kind  = out_res_ff.result_kind;
   assign rsp_if.payload_byte = out_res_ff.payload_byte;
   assign rsp_if.msg_type     = out_res_ff.msg_type;
   assign rsp_if.int_value    = out_res_ff.int_value;
   assign rsp_if.str_length   = out_res_ff.str_length;
   assign rsp_if.status       = out_res_ff.status;

endmodule

@@ hdl/rmd_step.sv @@
module rmd_step
   import rmd_pkg::*;
#(
   parameter int BUF_BYTES = RMD_BUF_BYTES,
   parameter int CNT_W     = $clog2(BUF_BYTES)
) (
   input  rmd_state_type        cur_state,
   input  logic [CNT_W-1:0]     cur_count,
   input  logic [CNT_W-1:0]     cur_remaining,
   input  logic [7:0]           data_byte,
   input  logic                 buffer_end,
   output rmd_state_type        nxt_state,
   output logic [CNT_W-1:0]     nxt_count,
   output logic [CNT_W-1:0]     nxt_remaining,
   output logic                 fire,
   output rmd_result_type       result
);

   logic        is_digit;
   logic [3:0]  digit_val;
   logic [35:0] acc;
   logic [35:0] limit;

   // Decimal accumulate: magnitude * 10 + digit
   assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign digit_val = 4'(data_byte - CH_ZERO);
   assign acc       = {1'b0, cur_state.magnitude, 3'b000}
                    + {3'b000, cur_state.magnitude, 1'b0}
                    + {32'd0, digit_val};
   assign limit     = cur_state.is_negative ? LIMIT_NEG : LIMIT_POS;

   always_comb begin
      nxt_state     = cur_state;
      nxt_count     = cur_count;
      nxt_remaining = cur_remaining;
      fire          = 1'b0;
      result        = '0;

      case (cur_state.phase)
         // First byte picks the message type
         PH_TYPE: begin
            nxt_state.magnitude   = '0;
            nxt_state.is_negative = 1'b0;
            nxt_state.digit_seen  = 1'b0;
            nxt_count             = '0;
            nxt_remaining         = '0;
            case (data_byte)
               CH_PLUS: begin
                  nxt_state.type_code = TY_SIMPLE;
                  nxt_state.phase     = PH_TEXT;
               end
               CH_MINUS: begin
                  nxt_state.type_code = TY_ERROR;
                  nxt_state.phase     = PH_TEXT;
               end
               CH_COLON: begin
                  nxt_state.type_code = TY_INT;
                  nxt_state.phase     = PH_SIGN;
               end
               CH_DOLLAR: begin
                  nxt_state.type_code = TY_BULK;
                  nxt_state.phase     = PH_SIGN;
               end
               default: begin
                  nxt_state.type_code = TY_SIMPLE;
                  nxt_state.phase     = PH_DRAIN;
                  fire                = 1'b1;
                  result.result_kind  = KIND_FINAL;
                  result.msg_type     = TY_SIMPLE;
                  result.status       = ST_BAD_TYPE;
               end
            endcase
         end

         // Optional sign, then decimal digits up to CR
         PH_SIGN, PH_DIGITS: begin
            nxt_state.phase = PH_DIGITS;
            if ((cur_state.phase == PH_SIGN)
                && ((data_byte == CH_PLUS) || (data_byte == CH_MINUS))) begin
               nxt_state.is_negative = (data_byte == CH_MINUS);
            end else if (is_digit) begin
               if (acc > limit) begin
                  nxt_state.phase    = PH_DRAIN;
                  fire               = 1'b1;
                  result.result_kind = KIND_FINAL;
                  result.msg_type    = cur_state.type_code;
                  result.status      = ST_OVERFLOW;
               end else begin
                  nxt_state.magnitude  = acc[31:0];
                  nxt_state.digit_seen = 1'b1;
               end
            end else if (!cur_state.digit_seen) begin
               nxt_state.phase    = PH_DRAIN;
               fire               = 1'b1;
               result.result_kind = KIND_FINAL;
               result.msg_type    = cur_state.type_code;
               result.status      = ST_NO_DIGITS;
            end else if (data_byte == CH_CR) begin
               nxt_state.phase = PH_NUM_LF;
            end else begin
               nxt_state.phase    = PH_DRAIN;
               fire               = 1'b1;
               result.result_kind = KIND_FINAL;
               result.msg_type    = cur_state.type_code;
               result.status      = ST_FRAMING;
            end
         end

         // LF closes the number: integer result or bulk length check
         PH_NUM_LF: begin
            fire               = 1'b1;
            result.result_kind = KIND_FINAL;
            nxt_state.phase    = PH_DRAIN;
            result.msg_type    = cur_state.type_code;
            if (data_byte != CH_LF) begin
               result.status = ST_FRAMING;
            end else if (cur_state.type_code == TY_INT) begin
               result.msg_type  = TY_INT;
               result.int_value = cur_state.is_negative ? -$signed(cur_state.magnitude)
                                                        : $signed(cur_state.magnitude);
               result.status    = ST_OK;
            end else if (cur_state.is_negative && (cur_state.magnitude == 32'd1)) begin
               result.msg_type = TY_NULL;
               result.status   = ST_OK;
            end else if (cur_state.is_negative && (cur_state.magnitude != 32'd0)) begin
               result.status = ST_NEGATIVE;
            end else if (cur_state.magnitude >= 32'(BUF_BYTES)) begin
               result.status = ST_TOO_LONG;
            end else begin
               fire          = 1'b0;
               result        = '0;
               nxt_remaining = cur_state.magnitude[CNT_W-1:0];
               nxt_count     = '0;
               nxt_state.phase = (cur_state.magnitude != 32'd0) ? PH_BULK_DATA : PH_BULK_CR;
            end
         end

         // Simple and error text, streamed up to CR
         PH_TEXT: begin
            if (data_byte == CH_CR) begin
               nxt_state.phase = PH_TEXT_LF;
            end else if (cur_count >= CNT_W'(BUF_BYTES - 1)) begin
               nxt_state.phase    = PH_DRAIN;
               fire               = 1'b1;
               result.result_kind = KIND_FINAL;
               result.msg_type    = cur_state.type_code;
               result.status      = ST_TOO_LONG;
            end else begin
               fire                = 1'b1;
               result.result_kind  = KIND_PAYLOAD;
               result.payload_byte = data_byte;
               nxt_count           = cur_count + CNT_W'(1);
            end
         end

         PH_TEXT_LF: begin
            fire               = 1'b1;
            result.result_kind = KIND_FINAL;
            result.msg_type    = cur_state.type_code;
            nxt_state.phase    = PH_DRAIN;
            if (data_byte == CH_LF) begin
               result.str_length = STR_LEN_W'(cur_count);
               result.status     = ST_OK;
            end else begin
               result.status = ST_FRAMING;
            end
         end

         // Counted bulk payload
         PH_BULK_DATA: begin
            fire                = 1'b1;
            result.result_kind  = KIND_PAYLOAD;
            result.payload_byte = data_byte;
            nxt_count           = cur_count + CNT_W'(1);
            nxt_remaining       = cur_remaining - CNT_W'(1);
            if (cur_remaining == CNT_W'(1)) begin
               nxt_state.phase = PH_BULK_CR;
            end
         end

         PH_BULK_CR: begin
            if (data_byte == CH_CR) begin
               nxt_state.phase = PH_BULK_LF;
            end else begin
               nxt_state.phase    = PH_DRAIN;
               fire               = 1'b1;
               result.result_kind = KIND_FINAL;
               result.msg_type    = cur_state.type_code;
               result.status      = ST_FRAMING;
            end
         end

         PH_BULK_LF: begin
            fire               = 1'b1;
            result.result_kind = KIND_FINAL;
            nxt_state.phase    = PH_DRAIN;
            if (data_byte == CH_LF) begin
               result.msg_type   = TY_BULK;
               result.str_length = STR_LEN_W'(cur_count);
               result.status     = ST_OK;
            end else begin
               result.msg_type = cur_state.type_code;
               result.status   = ST_FRAMING;
            end
         end

         default: begin
            // drain: bytes ignored until the buffer end
         end
      endcase

      // Buffer end: unfinished message is truncated, next byte starts anew
      if (buffer_end) begin
         if ((nxt_state.phase != PH_DRAIN) && (nxt_state.phase != PH_TYPE)) begin
            fire               = 1'b1;
            result             = '0;
            result.result_kind = KIND_FINAL;
            result.msg_type    = nxt_state.type_code;
            result.status      = ST_TRUNCATED;
         end
         nxt_state.phase = PH_TYPE;
      end
   end

endmodule
